// File: rtl/core/plst_pkg.sv
// plst_pkg: shared constants, codes and controller/datapath interface types
// for the positional list store. No dependencies.
`default_nettype none
package plst_pkg;

    localparam int DEPTH = 64;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int PW    = 7;
    localparam int VW    = 32;
    localparam int SW    = 2;
    localparam int XW    = ((CW > PW) ? CW : PW) + 1;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic [SW-1:0] ST_OK     = 2'd0;
    localparam logic [SW-1:0] ST_BADPOS = 2'd1;
    localparam logic [SW-1:0] ST_FULL   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SH_RD,
        S_SH_WR,
        S_INS_WR,
        S_RD_CAP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic rd_pos;
        logic init_idx;
        logic rd_shift;
        logic wr_shift;
        logic wr_ins;
        logic cap_read;
        logic set_bad;
        logic set_full;
        logic cnt_inc;
        logic cnt_dec;
    } dp_cmd_t;

    typedef struct packed {
        logic bad_pos;
        logic full;
        logic is_insert;
        logic is_remove;
        logic is_read;
        logic shift_needed;
        logic last;
    } dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/core/plst_ram.sv
// plst_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module plst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/plst_dp.sv
// plst_dp: datapath of the positional list store: word registers, entry
// count, shift index and the entry RAM. Depends on plst_pkg and plst_ram.
`default_nettype none
module plst_dp (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [1:0]               command,
    input  wire logic [plst_pkg::PW-1:0]  position,
    input  wire logic [plst_pkg::VW-1:0]  value,
    input  wire plst_pkg::dp_cmd_t        cmd,
    output plst_pkg::dp_stat_t            stat,
    output logic      [plst_pkg::VW-1:0]  read_value,
    output logic      [plst_pkg::SW-1:0]  status,
    output logic      [plst_pkg::PW-1:0]  count
);

    logic [1:0]                cmd_reg;
    logic [plst_pkg::PW-1:0]   pos_reg;
    logic [plst_pkg::VW-1:0]   val_reg;
    logic [plst_pkg::VW-1:0]   rd_reg;
    logic [plst_pkg::SW-1:0]   status_reg;
    logic [plst_pkg::CW-1:0]   cnt_reg, cnt_next;
    logic [plst_pkg::AW-1:0]   idx_reg, idx_next;

    logic [plst_pkg::XW-1:0]   pos_x, cnt_x, pos_m1_x;
    logic [plst_pkg::AW-1:0]   pos_m1, cnt_m1;
    logic                      is_insert, is_remove, is_read;

    logic                      ram_we, ram_re;
    logic [plst_pkg::AW-1:0]   ram_waddr, ram_raddr;
    logic [plst_pkg::VW-1:0]   ram_wdata, ram_rdata;

    assign pos_x    = plst_pkg::XW'(pos_reg);
    assign cnt_x    = plst_pkg::XW'(cnt_reg);
    assign pos_m1_x = pos_x - plst_pkg::XW'(1);
    assign pos_m1   = pos_m1_x[plst_pkg::AW-1:0];
    assign cnt_m1   = plst_pkg::AW'(cnt_x - plst_pkg::XW'(1));

    assign is_insert = (cmd_reg == plst_pkg::CMD_INSERT);
    assign is_remove = (cmd_reg == plst_pkg::CMD_REMOVE);
    assign is_read   = (cmd_reg == plst_pkg::CMD_READ);

    always_comb
    begin
        stat.is_insert = is_insert;
        stat.is_remove = is_remove;
        stat.is_read   = is_read;
        stat.full      = (cnt_x == plst_pkg::XW'(plst_pkg::DEPTH));
        if (is_insert)
        begin
            stat.bad_pos      = (pos_x == '0) || (pos_x > cnt_x + plst_pkg::XW'(1));
            stat.shift_needed = (pos_x <= cnt_x);
            stat.last         = (idx_reg == pos_m1);
        end
        else
        begin
            stat.bad_pos      = (pos_x == '0) || (pos_x > cnt_x);
            stat.shift_needed = (pos_x < cnt_x);
            stat.last         = (idx_reg == cnt_m1);
        end
    end

    // insert moves entries back (source walks down), remove moves them forward
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.init_idx)
        begin
            idx_next = is_insert ? cnt_m1 : pos_reg[plst_pkg::AW-1:0] & '1;
            if (!is_insert)
            begin
                idx_next = plst_pkg::AW'(pos_x);
            end
        end
        else if (cmd.wr_shift)
        begin
            idx_next = is_insert ? idx_reg - plst_pkg::AW'(1) : idx_reg + plst_pkg::AW'(1);
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + plst_pkg::CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            cnt_next = cnt_reg - plst_pkg::CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.load)
        begin
            cmd_reg    <= command;
            pos_reg    <= position;
            val_reg    <= value;
            rd_reg     <= '0;
            status_reg <= plst_pkg::ST_OK;
        end
        else
        begin
            if (cmd.cap_read)
            begin
                rd_reg <= ram_rdata;
            end
            if (cmd.set_bad)
            begin
                status_reg <= plst_pkg::ST_BADPOS;
            end
            else if (cmd.set_full)
            begin
                status_reg <= plst_pkg::ST_FULL;
            end
        end
    end

    assign ram_re    = cmd.rd_pos | cmd.rd_shift;
    assign ram_raddr = cmd.rd_pos ? pos_m1 : idx_reg;
    assign ram_we    = cmd.wr_shift | cmd.wr_ins;
    assign ram_wdata = cmd.wr_ins ? val_reg : ram_rdata;

    always_comb
    begin
        if (cmd.wr_ins)
        begin
            ram_waddr = pos_m1;
        end
        else if (is_insert)
        begin
            ram_waddr = idx_reg + plst_pkg::AW'(1);
        end
        else
        begin
            ram_waddr = idx_reg - plst_pkg::AW'(1);
        end
    end

    plst_ram #(
        .WIDTH(plst_pkg::VW),
        .DEPTH(plst_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign read_value = rd_reg;
    assign status     = status_reg;
    assign count      = cnt_x[plst_pkg::PW-1:0];

endmodule
`default_nettype wire

// File: rtl/core/plst_ctrl.sv
// plst_ctrl: controller state machine of the positional list store; drives
// datapath commands from datapath status. Depends on plst_pkg.
`default_nettype none
module plst_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire plst_pkg::dp_stat_t stat,
    output plst_pkg::dp_cmd_t       cmd,
    output logic                    busy,
    output logic                    done
);

    plst_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= plst_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            plst_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = plst_pkg::S_CHECK;
                end
            end
            plst_pkg::S_CHECK:
            begin
                if (stat.is_insert)
                begin
                    if (stat.bad_pos || stat.full)
                    begin
                        state_next = plst_pkg::S_DONE;
                    end
                    else if (stat.shift_needed)
                    begin
                        state_next = plst_pkg::S_SH_RD;
                    end
                    else
                    begin
                        state_next = plst_pkg::S_INS_WR;
                    end
                end
                else if (stat.is_remove)
                begin
                    if (!stat.bad_pos && stat.shift_needed)
                    begin
                        state_next = plst_pkg::S_SH_RD;
                    end
                    else
                    begin
                        state_next = plst_pkg::S_DONE;
                    end
                end
                else if (stat.is_read && !stat.bad_pos)
                begin
                    state_next = plst_pkg::S_RD_CAP;
                end
                else
                begin
                    state_next = plst_pkg::S_DONE;
                end
            end
            plst_pkg::S_SH_RD:
            begin
                state_next = plst_pkg::S_SH_WR;
            end
            plst_pkg::S_SH_WR:
            begin
                if (!stat.last)
                begin
                    state_next = plst_pkg::S_SH_RD;
                end
                else if (stat.is_insert)
                begin
                    state_next = plst_pkg::S_INS_WR;
                end
                else
                begin
                    state_next = plst_pkg::S_DONE;
                end
            end
            plst_pkg::S_INS_WR:
            begin
                state_next = plst_pkg::S_DONE;
            end
            plst_pkg::S_RD_CAP:
            begin
                state_next = plst_pkg::S_DONE;
            end
            plst_pkg::S_DONE:
            begin
                state_next = plst_pkg::S_IDLE;
            end
            default:
            begin
                state_next = plst_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        case (state_reg)
            plst_pkg::S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            plst_pkg::S_CHECK:
            begin
                // read at the requested position is issued speculatively
                cmd.rd_pos   = 1'b1;
                cmd.set_bad  = stat.bad_pos &&
                               (stat.is_insert || stat.is_remove || stat.is_read);
                cmd.set_full = stat.is_insert && !stat.bad_pos && stat.full;
                cmd.init_idx = (stat.is_insert || stat.is_remove) && !stat.bad_pos &&
                               !(stat.is_insert && stat.full) && stat.shift_needed;
                cmd.cnt_dec  = stat.is_remove && !stat.bad_pos && !stat.shift_needed;
            end
            plst_pkg::S_SH_RD:
            begin
                cmd.rd_shift = 1'b1;
            end
            plst_pkg::S_SH_WR:
            begin
                cmd.wr_shift = 1'b1;
                cmd.cnt_dec  = stat.last && stat.is_remove;
            end
            plst_pkg::S_INS_WR:
            begin
                cmd.wr_ins  = 1'b1;
                cmd.cnt_inc = 1'b1;
            end
            plst_pkg::S_RD_CAP:
            begin
                cmd.cap_read = 1'b1;
            end
            plst_pkg::S_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/core/positional_list_store.sv
// positional_list_store: ordered list of signed 32-bit words, insert/remove/read by position.
// A failed item goes from start through a check to done; a read adds a capture step. Insert
// and remove move up to DEPTH-1 entries, one RAM read and one RAM write per moved entry;
// insert then writes the new word. One item at a time: busy stays high until done.
// done strobes for one cycle with read_value, status and count; no back-pressure.
// reset (rst_n low, async) empties the list; RAM contents are not cleared.
`default_nettype none
module positional_list_store (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [1:0]               command,
    input  wire logic [plst_pkg::PW-1:0]  position,
    input  wire logic [plst_pkg::VW-1:0]  value,
    output logic                          done,
    output logic      [plst_pkg::VW-1:0]  read_value,
    output logic      [plst_pkg::SW-1:0]  status,
    output logic      [plst_pkg::PW-1:0]  count
);

    plst_pkg::dp_cmd_t  dp_cmd;
    plst_pkg::dp_stat_t dp_stat;

    plst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (dp_stat),
        .cmd   (dp_cmd),
        .busy  (busy),
        .done  (done)
    );

    plst_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .command    (command),
        .position   (position),
        .value      (value),
        .cmd        (dp_cmd),
        .stat       (dp_stat),
        .read_value (read_value),
        .status     (status),
        .count      (count)
    );

endmodule
`default_nettype wire

// File: tb/plst_checker.sv
// plst_checker: shadow copy of the positional list store, fed by the command
// and result ports; flags any result that differs. Depends on plst_pkg.
`timescale 1ns / 1ps
module plst_checker (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic                     busy,
    input  wire logic [1:0]               command,
    input  wire logic [plst_pkg::PW-1:0]  position,
    input  wire logic [plst_pkg::VW-1:0]  value,
    input  wire logic                     done,
    input  wire logic [plst_pkg::VW-1:0]  read_value,
    input  wire logic [plst_pkg::SW-1:0]  status,
    input  wire logic [plst_pkg::PW-1:0]  count,
    output int                            errors,
    output int                            expected_left,
    output int                            stored_count,
    output int                            n_checked,
    output int                            n_badpos,
    output int                            n_full
);
    import plst_pkg::*;

    typedef struct {
        logic [VW-1:0] rd;
        logic [SW-1:0] st;
        logic [PW-1:0] cnt;
    } reply_t;

    logic [VW-1:0] slots [DEPTH];
    int            n_stored;
    reply_t        awaited_replies [$];

    // update the shadow list for one command and return the reply it gives
    function automatic reply_t apply_command(logic [1:0] cmd, logic [PW-1:0] pos,
                                             logic [VW-1:0] val);
        reply_t r;
        int     p;
        p = int'(pos);
        r.rd = '0;
        r.st = ST_OK;
        case (cmd)
            CMD_INSERT:
            begin
                if (p < 1 || p > n_stored + 1)
                    r.st = ST_BADPOS;
                else if (n_stored >= DEPTH)
                    r.st = ST_FULL;
                else
                begin
                    for (int i = n_stored; i >= p; i--)
                        slots[i] = slots[i-1];
                    slots[p-1] = val;
                    n_stored++;
                end
            end
            CMD_REMOVE:
            begin
                if (p < 1 || p > n_stored)
                    r.st = ST_BADPOS;
                else
                begin
                    for (int i = p; i < n_stored; i++)
                        slots[i-1] = slots[i];
                    n_stored--;
                end
            end
            CMD_READ:
            begin
                if (p < 1 || p > n_stored)
                    r.st = ST_BADPOS;
                else
                    r.rd = slots[p-1];
            end
            default: ;
        endcase
        r.cnt = PW'(n_stored);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        reply_t want;
        if (!rst_n)
        begin
            n_stored = 0;
            awaited_replies.delete();
            errors = 0;
            n_checked = 0;
            n_badpos = 0;
            n_full = 0;
        end
        else
        begin
            // result of an earlier word first, then the word taken at this edge
            if (done)
            begin
                if (awaited_replies.size() == 0)
                begin
                    $display("%0t: result with nothing pending, got rd=%0d st=%0d cnt=%0d",
                             $time, $signed(read_value), status, count);
                    errors++;
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    n_checked++;
                    if (want.st == ST_BADPOS)
                        n_badpos++;
                    if (want.st == ST_FULL)
                        n_full++;
                    if (read_value !== want.rd)
                    begin
                        $display("%0t: read_value mismatch, expected %0d, got %0d",
                                 $time, $signed(want.rd), $signed(read_value));
                        errors++;
                    end
                    if (status !== want.st)
                    begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.st, status);
                        errors++;
                    end
                    if (count !== want.cnt)
                    begin
                        $display("%0t: count mismatch, expected %0d, got %0d",
                                 $time, want.cnt, count);
                        errors++;
                    end
                end
            end
            if (start && !busy)
                awaited_replies.push_back(apply_command(command, position, value));
        end
        expected_left = awaited_replies.size();
        stored_count = n_stored;
    end

endmodule

// File: tb/positional_list_store_tb.sv
// positional_list_store_tb: drives directed and random list commands into the
// store; checking lives in plst_checker. Depends on plst_pkg and the RTL.
`timescale 1ns / 1ps
module positional_list_store_tb;
    import plst_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         RANDOM_WORDS = 1930;
    localparam int         IDLE_LIMIT  = 4000;
    localparam int         SETTLE      = 2 * DEPTH + 20;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic [1:0]     command;
    logic [PW-1:0]  position;
    logic [VW-1:0]  value;
    logic           busy;
    logic           done;
    logic [VW-1:0]  read_value;
    logic [SW-1:0]  status;
    logic [PW-1:0]  count;

    int errors, expected_left, stored_count, n_checked, n_badpos, n_full;
    int sent_by_cmd [4];
    int peak_count;
    int idle_cycles;

    positional_list_store dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .position   (position),
        .value      (value),
        .done       (done),
        .read_value (read_value),
        .status     (status),
        .count      (count)
    );

    plst_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .position      (position),
        .value         (value),
        .done          (done),
        .read_value    (read_value),
        .status        (status),
        .count         (count),
        .errors        (errors),
        .expected_left (expected_left),
        .stored_count  (stored_count),
        .n_checked     (n_checked),
        .n_badpos      (n_badpos),
        .n_full        (n_full)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // present one word, hold it until taken, then drop start
    task automatic issue(input logic [1:0] cmd, input logic [PW-1:0] pos,
                         input logic [VW-1:0] val, input int gap);
        repeat (gap) @(posedge clk);
        @(posedge clk);
        start    <= 1'b1;
        command  <= cmd;
        position <= pos;
        value    <= val;
        do
            @(posedge clk);
        while (busy);
        start <= 1'b0;
        sent_by_cmd[cmd]++;
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (expected_left != 0);
    endtask

    function automatic int pick_gap(bit burst);
        int roll;
        roll = $urandom_range(99);
        if (burst || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    function automatic logic [VW-1:0] pick_value();
        case ($urandom_range(19))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [PW-1:0] pick_position(logic [1:0] cmd, int n);
        int roll;
        int top;
        roll = $urandom_range(99);
        top = (cmd == CMD_INSERT) ? n + 1 : n;
        if (roll < 8)
            return PW'($urandom_range(65));
        if (roll < 18)
        begin
            case ($urandom_range(3))
                0: return PW'(1);
                1: return PW'(top);
                2: return PW'(top + 1);
                default: return PW'(0);
            endcase
        end
        if (top < 1)
            return PW'(1);
        return PW'($urandom_range(top, 1));
    endfunction

    initial
    begin : stimulus
        int          done_words;
        int          phase_left;
        int          mode;
        int          roll;
        bit          burst;
        logic [1:0]  cmd;

        rst_n    <= 1'b0;
        start    <= 1'b0;
        command  <= CMD_INSERT;
        position <= '0;
        value    <= '0;
        peak_count = 0;
        foreach (sent_by_cmd[i])
            sent_by_cmd[i] = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // empty list, edge positions, extreme values, unused command
        issue(CMD_READ,   7'd1,  32'h0,         0);
        issue(CMD_REMOVE, 7'd1,  32'h0,         0);
        issue(CMD_INSERT, 7'd0,  32'h1234_5678, 0);
        issue(CMD_INSERT, 7'd2,  32'h1234_5678, 1);
        issue(CMD_INSERT, 7'd1,  32'h8000_0000, 0);
        issue(CMD_INSERT, 7'd2,  32'h7fff_ffff, 2);
        issue(CMD_INSERT, 7'd1,  32'hffff_ffff, 0);
        issue(CMD_INSERT, 7'd4,  32'h0,         0);
        issue(CMD_INSERT, 7'd2,  32'h5a5a_5a5a, 0);
        issue(CMD_READ,   7'd0,  32'h0,         0);
        issue(CMD_READ,   7'd1,  32'hffff_ffff, 0);
        issue(CMD_READ,   7'd5,  32'h0,         3);
        issue(CMD_READ,   7'd6,  32'h0,         0);
        issue(CMD_UNUSED, 7'd65, 32'hffff_ffff, 0);
        issue(CMD_REMOVE, 7'd6,  32'h0,         0);
        issue(CMD_REMOVE, 7'd0,  32'h0,         0);
        issue(CMD_REMOVE, 7'd1,  32'h0,         0);
        issue(CMD_REMOVE, 7'd4,  32'h0,         1);
        issue(CMD_REMOVE, 7'd2,  32'h0,         0);
        issue(CMD_READ,   7'd65, 32'h0,         0);
        issue(CMD_INSERT, 7'd65, 32'h0,         0);
        issue(CMD_READ,   7'd2,  32'h0,         0);
        drain();

        // phases that grow, shrink or churn the list so it reaches full and empty
        done_words = 0;
        phase_left = 0;
        mode = 0;
        burst = 1'b0;
        while (done_words < RANDOM_WORDS)
        begin
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(120, 20);
                mode = $urandom_range(2);
                burst = ($urandom_range(3) == 0);
            end
            @(negedge clk);
            if (stored_count > peak_count)
                peak_count = stored_count;
            roll = $urandom_range(99);
            if (roll == 0)
                cmd = CMD_UNUSED;
            else if (mode == 0)
                cmd = (roll < 65) ? CMD_INSERT : (roll < 80) ? CMD_REMOVE : CMD_READ;
            else if (mode == 1)
                cmd = (roll < 15) ? CMD_INSERT : (roll < 75) ? CMD_REMOVE : CMD_READ;
            else
                cmd = (roll < 35) ? CMD_INSERT : (roll < 65) ? CMD_REMOVE : CMD_READ;
            issue(cmd, pick_position(cmd, stored_count), pick_value(), pick_gap(burst));
            done_words++;
            phase_left--;
            if (done_words % 300 == 0)
                drain();
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        $display("sent %0d inserts, %0d removes, %0d reads, %0d unused commands",
                 sent_by_cmd[CMD_INSERT], sent_by_cmd[CMD_REMOVE],
                 sent_by_cmd[CMD_READ], sent_by_cmd[CMD_UNUSED]);
        $display("%0d results checked: %0d invalid position, %0d store full, peak count %0d",
                 n_checked, n_badpos, n_full, peak_count);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
